// ===== rtl/core/vpap_pkg.sv =====
// Package for the video processor access port.
// Holds the shared constants, codes, the memory request and response structs and the command decode functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vpap_pkg;

    localparam int VRAM_BYTES          = 65536;
    localparam int VRAM_WORDS          = VRAM_BYTES / 2;
    localparam int VRAM_AW             = $clog2(VRAM_WORDS);
    localparam int SMALL_RAM_WORDS_DEF = 64;
    localparam int REG_COUNT_DEF       = 32;

    localparam logic [1:0] MODE_DATA_WR = 2'd0;
    localparam logic [1:0] MODE_CTRL_WR = 2'd1;
    localparam logic [1:0] MODE_DATA_RD = 2'd2;
    localparam logic [1:0] MODE_STAT_RD = 2'd3;

    localparam logic [7:0] KIND_VRAM_WR    = 8'h01;
    localparam logic [7:0] KIND_VRAM128_WR = 8'h81;
    localparam logic [7:0] KIND_CRAM_WR    = 8'h03;
    localparam logic [7:0] KIND_VSRAM_WR   = 8'h05;
    localparam logic [7:0] KIND_VRAM_RD    = 8'h00;
    localparam logic [7:0] KIND_CRAM_RD    = 8'h08;
    localparam logic [7:0] KIND_VSRAM_RD   = 8'h04;

    localparam logic [4:0] REG_MODE2       = 5'd1;
    localparam logic [4:0] REG_INCREMENT   = 5'd15;
    localparam logic [4:0] REG_LEN_LO      = 5'd19;
    localparam logic [4:0] REG_LEN_HI      = 5'd20;
    localparam logic [4:0] REG_SRC_LO      = 5'd21;
    localparam logic [4:0] REG_SRC_MID     = 5'd22;
    localparam logic [4:0] REG_SRC_HI      = 5'd23;
    localparam logic [4:0] REG_LEGACY_LAST = 5'd10;

    localparam logic [1:0] XFER_FILL = 2'd2;
    localparam logic [1:0] XFER_COPY = 2'd3;

    typedef struct packed {
        logic [VRAM_AW-1:0] vram_addr;
        logic               vram_we;
        logic [1:0]         vram_be;
        logic [15:0]        vram_wdata;
        logic [5:0]         small_idx;
        logic               cram_we;
        logic               vsram_we;
        logic [15:0]        small_wdata;
    } t_mem_req;

    typedef struct packed {
        logic [15:0] vram_rdata;
        logic [15:0] cram_rdata;
        logic [15:0] vsram_rdata;
        logic        ready;
    } t_mem_rsp;

    function automatic logic [7:0] f_decode_kind(input logic [31:0] c, input logic mode128);
        logic [7:0] k;
        k = {4'b0000, c[5:4], c[31:30]};
        if (k == KIND_VRAM_WR) begin
            k[7] = mode128;
        end
        return k;
    endfunction

    function automatic logic [15:0] f_decode_addr(input logic [31:0] c);
        return {c[1:0], c[29:16]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/video_processor_access_port.sv =====
// A control write or status read goes from idle through the done state to the output register,
// a data access first through the write or read state. A fill steps through the fill state for
// each byte, a copy through the read and write states, bound by the single video RAM port.
// One item is in work at a time. Reset is synchronous and active low; afterwards the video RAM
// clearing pass zeroes every word, during which no item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module video_processor_access_port #(
    parameter int SMALL_RAM_WORDS = vpap_pkg::SMALL_RAM_WORDS_DEF,
    parameter int REG_COUNT       = vpap_pkg::REG_COUNT_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // word
    input  wire  [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata    // read_word
);

    localparam int RW = $clog2(REG_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE, ST_WRITE, ST_RDATA, ST_FILL, ST_COPY_RD, ST_COPY_WR, ST_DONE
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_regs [REG_COUNT];
    logic [7:0]  n_regs [REG_COUNT];
    logic [31:0] r_latch, n_latch;
    logic        r_swd, n_swd;
    logic [7:0]  r_kind, n_kind;
    logic [15:0] r_addr, n_addr;
    logic        r_upper, n_upper;
    logic        r_busy, n_busy;
    logic [15:0] r_data, n_data;
    logic [16:0] r_cnt, n_cnt;
    logic [15:0] r_src, n_src;
    logic [15:0] r_res, n_res;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_data, n_out_data;

    vpap_pkg::t_mem_req w_req;
    vpap_pkg::t_mem_rsp w_rsp;

    logic [7:0]  w_r1, w_inc, w_r23;
    logic [15:0] w_len_raw;
    logic [16:0] w_len;
    logic [24:0] w_span;
    logic [31:0] w_new_latch;
    logic [4:0]  w_num;
    logic [15:0] w_swapped;
    logic [16:0] w_full;
    logic [15:0] w_b128;
    logic [7:0]  w_copy_byte;
    logic        w_accept;

    assign w_r1      = r_regs[vpap_pkg::REG_MODE2];
    assign w_inc     = r_regs[vpap_pkg::REG_INCREMENT];
    assign w_r23     = r_regs[vpap_pkg::REG_SRC_HI];
    assign w_len_raw = {r_regs[vpap_pkg::REG_LEN_HI], r_regs[vpap_pkg::REG_LEN_LO]};
    assign w_len     = (w_len_raw == 16'h0000) ? 17'h10000 : {1'b0, w_len_raw};
    assign w_span    = 25'(w_len) * 25'(w_inc);
    assign w_new_latch = {r_latch[31:16], s_axis_tdata};
    assign w_num     = s_axis_tdata[12:8];
    assign w_swapped = r_addr[0] ? {r_data[7:0], r_data[15:8]} : r_data;
    assign w_full    = {r_upper, r_addr};
    assign w_b128    = {w_full[16:11], w_full[9:2], w_full[10], w_full[1]};
    assign w_copy_byte = r_src[0] ? w_rsp.vram_rdata[15:8] : w_rsp.vram_rdata[7:0];
    assign w_accept  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE) && w_rsp.ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        w_req             = '0;
        w_req.vram_addr   = r_addr[15:1];
        w_req.small_idx   = r_addr[6:1];
        w_req.small_wdata = r_data;
        unique case (r_state)
            ST_WRITE: begin
                unique case (r_kind)
                    vpap_pkg::KIND_VRAM_WR: begin
                        w_req.vram_we    = 1'b1;
                        w_req.vram_be    = 2'b11;
                        w_req.vram_wdata = w_swapped;
                    end
                    vpap_pkg::KIND_VRAM128_WR: begin
                        w_req.vram_addr  = w_b128[15:1];
                        w_req.vram_we    = 1'b1;
                        w_req.vram_be    = {w_b128[0], !w_b128[0]};
                        w_req.vram_wdata = {r_data[7:0], r_data[7:0]};
                    end
                    vpap_pkg::KIND_CRAM_WR: begin
                        w_req.cram_we = 1'b1;
                    end
                    vpap_pkg::KIND_VSRAM_WR: begin
                        w_req.vsram_we = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_FILL: begin
                w_req.vram_we    = 1'b1;
                w_req.vram_be    = {r_addr[0], !r_addr[0]};
                w_req.vram_wdata = {r_data[15:8], r_data[15:8]};
            end
            ST_COPY_RD: begin
                w_req.vram_addr = r_src[15:1];
            end
            ST_COPY_WR: begin
                w_req.vram_we    = 1'b1;
                w_req.vram_be    = {r_addr[0], !r_addr[0]};
                w_req.vram_wdata = {w_copy_byte, w_copy_byte};
            end
            ST_IDLE, ST_RDATA, ST_DONE: begin
            end
        endcase
    end

    vpap_mem #(
        .SMALL_RAM_WORDS(SMALL_RAM_WORDS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_regs      = r_regs;
        n_latch     = r_latch;
        n_swd       = r_swd;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_upper     = r_upper;
        n_busy      = r_busy;
        n_data      = r_data;
        n_cnt       = r_cnt;
        n_src       = r_src;
        n_res       = r_res;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_data  = s_axis_tdata;
                    n_res   = 16'h0000;
                    n_state = ST_DONE;
                    unique case (s_axis_tuser)
                        vpap_pkg::MODE_DATA_WR: begin
                            if (r_swd) begin
                                n_kind  = vpap_pkg::f_decode_kind(r_latch, w_r1[7]);
                                n_addr  = vpap_pkg::f_decode_addr(r_latch);
                                n_upper = r_latch[2];
                                n_swd   = 1'b0;
                            end
                            n_state = ST_WRITE;
                        end
                        vpap_pkg::MODE_CTRL_WR: begin
                            if (r_swd) begin
                                n_latch = w_new_latch;
                                n_swd   = 1'b0;
                                n_kind  = vpap_pkg::f_decode_kind(w_new_latch, w_r1[7]);
                                n_addr  = vpap_pkg::f_decode_addr(w_new_latch);
                                n_upper = w_new_latch[2];
                                if (s_axis_tdata[7] && w_r1[4] && w_r23[7:6] == vpap_pkg::XFER_COPY) begin
                                    n_busy  = 1'b1;
                                    n_src   = {r_regs[vpap_pkg::REG_SRC_MID],
                                               r_regs[vpap_pkg::REG_SRC_LO]};
                                    n_cnt   = w_len;
                                    n_regs[vpap_pkg::REG_LEN_LO] = 8'h00;
                                    n_regs[vpap_pkg::REG_LEN_HI] = 8'h00;
                                    {n_regs[vpap_pkg::REG_SRC_MID], n_regs[vpap_pkg::REG_SRC_LO]} =
                                        n_src + w_len[15:0];
                                    n_state = ST_COPY_RD;
                                end
                            end else if (s_axis_tdata[15:14] == 2'b10) begin
                                n_kind = vpap_pkg::KIND_VRAM_RD;
                                if (!(w_num > vpap_pkg::REG_LEGACY_LAST && !w_r1[2])
                                    && ({1'b0, w_num} < 6'(REG_COUNT))) begin
                                    n_regs[w_num[RW-1:0]] = s_axis_tdata[7:0];
                                end
                            end else begin
                                n_latch = {s_axis_tdata, r_latch[15:0]};
                                n_swd   = 1'b1;
                            end
                        end
                        vpap_pkg::MODE_DATA_RD: begin
                            n_state = ST_RDATA;
                        end
                        vpap_pkg::MODE_STAT_RD: begin
                            n_res = {12'h000, !w_r1[6], 1'b0, r_busy, 1'b0};
                            n_swd = 1'b0;
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                n_addr  = r_addr + 16'(w_inc);
                n_state = ST_DONE;
                if (r_latch[7] && w_r1[4] && w_r23[7:6] == vpap_pkg::XFER_FILL) begin
                    n_busy = 1'b1;
                    n_regs[vpap_pkg::REG_LEN_LO] = 8'h00;
                    n_regs[vpap_pkg::REG_LEN_HI] = 8'h00;
                    {n_regs[vpap_pkg::REG_SRC_MID], n_regs[vpap_pkg::REG_SRC_LO]} =
                        {r_regs[vpap_pkg::REG_SRC_MID], r_regs[vpap_pkg::REG_SRC_LO]}
                        + w_len[15:0];
                    if (r_kind == vpap_pkg::KIND_VRAM_WR) begin
                        n_cnt   = w_len;
                        n_state = ST_FILL;
                    end else begin
                        n_addr = r_addr + 16'(w_inc) + w_span[15:0];
                    end
                end
            end
            ST_FILL: begin
                n_addr = r_addr + 16'(w_inc);
                n_cnt  = r_cnt - 17'd1;
                if (r_cnt == 17'd1) begin
                    n_state = ST_DONE;
                end
            end
            ST_COPY_RD: begin
                n_state = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                n_addr  = r_addr + 16'(w_inc);
                n_src   = r_src + 16'd1;
                n_cnt   = r_cnt - 17'd1;
                n_state = (r_cnt == 17'd1) ? ST_DONE : ST_COPY_RD;
            end
            ST_RDATA: begin
                n_addr  = r_addr + 16'(w_inc);
                n_state = ST_DONE;
                unique case (r_kind)
                    vpap_pkg::KIND_VRAM_RD:  n_res = w_rsp.vram_rdata;
                    vpap_pkg::KIND_CRAM_RD:  n_res = w_rsp.cram_rdata;
                    vpap_pkg::KIND_VSRAM_RD: n_res = w_rsp.vsram_rdata;
                    default:                 n_res = 16'h0000;
                endcase
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_regs      <= '{default: 8'h00};
            r_latch     <= '0;
            r_swd       <= 1'b0;
            r_kind      <= '0;
            r_addr      <= '0;
            r_upper     <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_regs      <= n_regs;
            r_latch     <= n_latch;
            r_swd       <= n_swd;
            r_kind      <= n_kind;
            r_addr      <= n_addr;
            r_upper     <= n_upper;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_data     <= n_data;
        r_cnt      <= n_cnt;
        r_src      <= n_src;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

`ifndef NO_ASSERTIONS
    a_busy_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_busy))
        else $error("transfer busy bit dropped without reset");

    a_ready_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> w_rsp.ready)
        else $error("item accepted during the clearing pass");

    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL || r_state == ST_COPY_WR || r_state == ST_COPY_RD) |-> r_cnt != 17'd0)
        else $error("transfer running with zero count");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !m_axis_tready) |=> r_state == ST_DONE)
        else $error("result lost while output is stalled");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/vpap_mem.sv =====
// Memories of the access port: video RAM as byte-laned words, colour and scroll RAM.
// Runs the video RAM clearing pass after reset. Depends on vpap_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vpap_mem #(
    parameter int SMALL_RAM_WORDS = vpap_pkg::SMALL_RAM_WORDS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  vpap_pkg::t_mem_req  i_req,
    output vpap_pkg::t_mem_rsp  o_rsp
);

    localparam int SW = $clog2(SMALL_RAM_WORDS);

    logic [15:0] r_vram  [vpap_pkg::VRAM_WORDS];
    logic [15:0] r_cram  [SMALL_RAM_WORDS];
    logic [15:0] r_vsram [SMALL_RAM_WORDS];
    logic [SMALL_RAM_WORDS-1:0] r_cram_vld;
    logic [SMALL_RAM_WORDS-1:0] r_vsram_vld;

    logic                        r_clearing;
    logic [vpap_pkg::VRAM_AW-1:0] r_clr_idx;
    logic [15:0]                 r_vram_rdata;
    logic [15:0]                 r_cram_rdata;
    logic [15:0]                 r_vsram_rdata;

    logic          w_in_range;
    logic [SW-1:0] w_idx;

    assign w_in_range = {1'b0, i_req.small_idx} < 7'(SMALL_RAM_WORDS);
    assign w_idx      = i_req.small_idx[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (&r_clr_idx) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_vram[r_clr_idx] <= 16'h0000;
        end else if (i_req.vram_we) begin
            if (i_req.vram_be[0]) begin
                r_vram[i_req.vram_addr][7:0] <= i_req.vram_wdata[7:0];
            end
            if (i_req.vram_be[1]) begin
                r_vram[i_req.vram_addr][15:8] <= i_req.vram_wdata[15:8];
            end
        end
        r_vram_rdata <= r_vram[i_req.vram_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cram_vld  <= '0;
            r_vsram_vld <= '0;
        end else if (w_in_range) begin
            if (i_req.cram_we) begin
                r_cram_vld[w_idx] <= 1'b1;
            end
            if (i_req.vsram_we) begin
                r_vsram_vld[w_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_range && i_req.cram_we) begin
            r_cram[w_idx] <= i_req.small_wdata;
        end
        if (w_in_range && i_req.vsram_we) begin
            r_vsram[w_idx] <= i_req.small_wdata;
        end
        r_cram_rdata  <= (w_in_range && r_cram_vld[w_idx]) ? r_cram[w_idx] : 16'h0000;
        r_vsram_rdata <= (w_in_range && r_vsram_vld[w_idx]) ? r_vsram[w_idx] : 16'h0000;
    end

    assign o_rsp.vram_rdata  = r_vram_rdata;
    assign o_rsp.cram_rdata  = r_cram_rdata;
    assign o_rsp.vsram_rdata = r_vsram_rdata;
    assign o_rsp.ready       = !r_clearing;

endmodule
`default_nettype wire
